@@ rtl/lpe_pkg.sv @@
// Shared types, constants and a helper function for the LED strip pulse encoder.
package lpe_pkg;

  localparam int unsigned BitsPerLed = 24;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned TickW      = 15;
  localparam int unsigned CntW       = $clog2(BitsPerLed);
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = TickW;
  localparam int unsigned ProdW      = 2 * ByteW;

  localparam logic [ByteW-1:0] BrightnessRst = 8'd255;
  localparam logic [TickW-1:0] OneHighRst    = 15'd28;
  localparam logic [TickW-1:0] ZeroHighRst   = 15'd14;
  localparam logic [TickW-1:0] LowTicksRst   = 15'd24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BRIGHTNESS = 2'd0,
    CFG_ONE_HIGH   = 2'd1,
    CFG_ZERO_HIGH  = 2'd2,
    CFG_LOW_TICKS  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] upper_byte;
    logic [ByteW-1:0] middle_byte;
    logic [ByteW-1:0] lower_byte;
    logic             last_led;
  } lpe_in_t;

  typedef struct packed {
    logic             bit_value;
    logic [TickW-1:0] high_ticks;
    logic [TickW-1:0] low_ticks;
    logic             last_of_led;
    logic             last_of_frame;
  } lpe_out_t;

  // Exact floor(p / 255) for any product of two bytes (p <= 255 * 255): (p + 1 + (p >> 8)) >> 8.
  function automatic logic [ByteW-1:0] div255(input logic [ProdW-1:0] p);
    logic [ProdW:0] s;
    s = {1'b0, p} + {{ProdW{1'b0}}, 1'b1} + {{(ByteW + 1){1'b0}}, p[ProdW-1:ByteW]};
    return s[ProdW-1:ByteW];
  endfunction

endpackage

@@ rtl/lpe_scale_lane.sv @@
// One brightness scaling lane: registered byte product followed by a divide by 255.
module lpe_scale_lane (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [lpe_pkg::ByteW-1:0]  byte_i,
  input  logic [lpe_pkg::ByteW-1:0]  brightness_i,
  output logic [lpe_pkg::ByteW-1:0]  scaled_o
);
  import lpe_pkg::*;

  logic [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= byte_i * brightness_i;
    end
  end

  assign scaled_o = div255(prod_q);

endmodule

@@ rtl/lpe_serializer.sv @@
// Merging stage: joins the lane results into one word and shifts out one pulse per cycle while not stalled.
module lpe_serializer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          word_valid_i,
  input  logic [lpe_pkg::BitsPerLed-1:0] word_i,
  input  logic                          last_led_i,
  input  logic [lpe_pkg::TickW-1:0]     one_high_i,
  input  logic [lpe_pkg::TickW-1:0]     zero_high_i,
  input  logic [lpe_pkg::TickW-1:0]     low_ticks_i,
  output logic                          load_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lpe_pkg::lpe_out_t             out_data_o
);
  import lpe_pkg::*;

  localparam logic [CntW-1:0] LastCnt = CntW'(BitsPerLed - 1);

  logic [BitsPerLed-1:0] word_q, word_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  last_q, last_d;
  logic                  out_xfer, final_pulse;

  assign final_pulse = (cnt_q == LastCnt);
  assign out_xfer    = busy_q && !out_stall_i;
  assign load_o      = word_valid_i && (!busy_q || (out_xfer && final_pulse));

  always_comb begin
    word_d = word_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    last_d = last_q;
    if (load_o) begin
      word_d = word_i;
      cnt_d  = '0;
      busy_d = 1'b1;
      last_d = last_led_i;
    end else if (out_xfer) begin
      if (final_pulse) begin
        busy_d = 1'b0;
      end else begin
        word_d = {word_q[BitsPerLed-2:0], 1'b0};
        cnt_d  = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    last_q <= last_d;
  end

  assign out_valid_o                = busy_q;
  assign out_data_o.bit_value       = word_q[BitsPerLed-1];
  assign out_data_o.high_ticks      = word_q[BitsPerLed-1] ? one_high_i : zero_high_i;
  assign out_data_o.low_ticks       = low_ticks_i;
  assign out_data_o.last_of_led     = final_pulse;
  assign out_data_o.last_of_frame   = final_pulse && last_q;

endmodule

@@ rtl/led_strip_pulse_encoder.sv @@
// Top level of the LED strip pulse encoder: configuration, scaling lanes and serializer.
//
// Usage: each input transaction on in_valid_i/in_stall_o carries one LED color
// word as three bytes plus a flag that marks the last LED of a frame. Each byte
// is scaled by the brightness register as byte * brightness / 255 (truncated),
// and the scaled 24-bit word is sent as 24 output transactions on
// out_valid_o/out_stall_i, most significant bit of the upper byte first. Each
// output transaction describes one pulse: the bit, its high time (one or zero
// high ticks) and the low time that follows it.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i with no
// handshake; it must only be changed while no LED is in flight.
// The first pulse of an LED is valid once it is loaded from the lane registers into
// the serializer. Throughput: one pulse per cycle while the receiver does not stall,
// set by the serializer that emits one bit per cycle. The next LED waits in
// the lane product registers, so pulses of consecutive LEDs follow gap-free.
// Reset clears all valid state and restores the register defaults.
// A stalled receiver holds the current pulse steady; input backs up once the
// lane stage holds a waiting LED.
module led_strip_pulse_encoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpe_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lpe_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lpe_pkg::lpe_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lpe_pkg::lpe_out_t             out_data_o
);
  import lpe_pkg::*;

  // Configuration registers.
  logic [ByteW-1:0] brightness_q;
  logic [TickW-1:0] one_high_q, zero_high_q, low_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= BrightnessRst;
      one_high_q   <= OneHighRst;
      zero_high_q  <= ZeroHighRst;
      low_ticks_q  <= LowTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BRIGHTNESS: brightness_q <= cfg_wdata_i[ByteW-1:0];
        CFG_ONE_HIGH:   one_high_q   <= cfg_wdata_i[TickW-1:0];
        CFG_ZERO_HIGH:  zero_high_q  <= cfg_wdata_i[TickW-1:0];
        CFG_LOW_TICKS:  low_ticks_q  <= cfg_wdata_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  // Lane stage: one product register per byte, plus the frame flag beside them.
  logic             lane_valid_q, lane_valid_d;
  logic             lane_last_q;
  logic             in_xfer, load;
  logic [ByteW-1:0] upper_s, middle_s, lower_s;

  assign in_stall_o = lane_valid_q && !load;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    lane_valid_d = lane_valid_q;
    if (in_xfer) begin
      lane_valid_d = 1'b1;
    end else if (load) begin
      lane_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_valid_q <= 1'b0;
    end else begin
      lane_valid_q <= lane_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      lane_last_q <= in_data_i.last_led;
    end
  end

  lpe_scale_lane u_lane_upper (
    .clk_i        (clk_i),
    .en_i         (in_xfer),
    .byte_i       (in_data_i.upper_byte),
    .brightness_i (brightness_q),
    .scaled_o     (upper_s)
  );

  lpe_scale_lane u_lane_middle (
    .clk_i        (clk_i),
    .en_i         (in_xfer),
    .byte_i       (in_data_i.middle_byte),
    .brightness_i (brightness_q),
    .scaled_o     (middle_s)
  );

  lpe_scale_lane u_lane_lower (
    .clk_i        (clk_i),
    .en_i         (in_xfer),
    .byte_i       (in_data_i.lower_byte),
    .brightness_i (brightness_q),
    .scaled_o     (lower_s)
  );

  // The serializer joins the three lanes and emits one pulse per cycle while the receiver does not stall.
  lpe_serializer u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (lane_valid_q),
    .word_i       ({upper_s, middle_s, lower_s}),
    .last_led_i   (lane_last_q),
    .one_high_i   (one_high_q),
    .zero_high_i  (zero_high_q),
    .low_ticks_i  (low_ticks_q),
    .load_o       (load),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

@@ rtl/lpe_checker.sv @@
// Port-level checker for the LED strip pulse encoder and its bind statement.
module lpe_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input lpe_pkg::lpe_in_t             in_data_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input lpe_pkg::lpe_out_t            out_data_o
);
  import lpe_pkg::*;

  // A stalled input word stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input word changed while stalled");

  // A stalled pulse stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output pulse changed while stalled");

  // The frame end only ever falls on the final pulse of an LED.
  a_frame_on_led_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_of_frame |-> out_data_o.last_of_led)
    else $error("last_of_frame without last_of_led");

  // The pulses of one LED follow each other without a gap.
  a_led_unbroken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_of_led |=> out_valid_o)
    else $error("gap inside the pulses of one LED");

  // With the serializer empty, a new LED is always taken.
  a_idle_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while no pulse is pending");

endmodule

bind led_strip_pulse_encoder lpe_checker u_lpe_checker (.*);
